@@ sv/clt_pkg.sv @@
`default_nettype none

package clt_pkg;

	// Result status codes.
	localparam logic [1:0] ST_ERROR    = 2'd0;
	localparam logic [1:0] ST_PARTIAL  = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;

	// Quote kinds, also reported as the token kind.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_STRING = 2'd1;
	localparam logic [1:0] KIND_CHAR   = 2'd2;

	// Escape sequence progress.
	typedef enum logic [1:0] {
		ESC_NONE      = 2'd0,
		ESC_BACKSLASH = 2'd1,
		ESC_OCTAL     = 2'd2,
		ESC_HEX       = 2'd3
	} esc_t;

	// Character codes.
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_V   = 8'h76;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Width of the reported logical character count.
	localparam int unsigned OUT_COUNT_WIDTH = 16;

	// One result beat.
	typedef struct packed {
		logic [1:0]                 status;
		logic [1:0]                 token_kind;
		logic                       is_wide;
		logic [OUT_COUNT_WIDTH-1:0] logical_chars;
	} result_t;

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
			((c >= CH_LC_A) && (c <= CH_LC_F)) ||
			((c >= CH_UC_A) && (c <= CH_UC_F));
	endfunction

	function automatic logic is_simple_esc(input logic [7:0] c);
		return (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_QMARK) ||
			(c == CH_BSLASH) || (c == CH_LC_A) || (c == CH_LC_B) ||
			(c == CH_LC_F) || (c == CH_LC_N) || (c == CH_LC_R) ||
			(c == CH_LC_T) || (c == CH_LC_V);
	endfunction

endpackage

`default_nettype wire

@@ sv/clt_in_if.sv @@
`default_nettype none

// Byte channel into the recogniser.
interface clt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

@@ sv/clt_out_if.sv @@
`default_nettype none

// Result channel out of the recogniser.
interface clt_out_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic [1:0]                          token_kind;
	logic                                is_wide;
	logic [clt_pkg::OUT_COUNT_WIDTH-1:0] logical_chars;

	modport source (output valid, output status, output token_kind, output is_wide,
		output logical_chars, input ready);
	modport sink (input valid, input status, input token_kind, input is_wide,
		input logical_chars, output ready);
endinterface

`default_nettype wire

@@ sv/c_literal_token_recognizer_core.sv @@
// C string literal and character constant recogniser.
// The req channel carries one source byte per beat, with start_req set on the
// first byte of a candidate token to clear all recogniser state first.
// The rsp channel returns exactly one result beat per accepted byte: status
// (error, partial, complete), token kind when complete, the wide flag and the
// saturating count of logical characters seen so far.
// The result of an accepted byte is registered into the result register, or into
// the skid register while rsp is stalled. Throughput is one byte per cycle while
// req.ready is high; the per-byte state update is a single level of decode logic
// between the recogniser state registers and the result register.
// The result register is backed by a one-beat skid register, so a byte is
// still taken while one result waits on a stalled receiver; req.ready drops
// only once both are full and rises again when rsp is taken.
// Reset clears the recogniser state and both result slots; no result is
// pending and req.ready is high after reset.
// Errors are sticky: after an error every byte reports error until a byte
// arrives with start_req set.
`default_nettype none

module c_literal_token_recognizer_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	clt_in_if.sink    req,
	clt_out_if.source rsp
);

	localparam int unsigned OCW = clt_pkg::OUT_COUNT_WIDTH;

	// Recogniser state.
	logic                   fault_q;
	logic                   wide_q;
	logic                   open_q;
	logic [1:0]             qkind_q;
	clt_pkg::esc_t          esc_q;
	logic [1:0]             elen_q;
	logic [COUNT_WIDTH-1:0] lcount_q;
	logic [1:0]             raw_q;     // bytes consumed, saturating at two

	// Result slots.
	logic             out_valid_q;
	logic             skid_valid_q;
	clt_pkg::result_t out_q;
	clt_pkg::result_t skid_q;

	// Next-state signals.
	logic                   cur_fault;
	logic                   cur_wide;
	logic                   cur_open;
	logic [1:0]             cur_qkind;
	clt_pkg::esc_t          cur_esc;
	logic [1:0]             cur_elen;
	logic [COUNT_WIDTH-1:0] cur_lcount;
	logic [1:0]             cur_raw;
	logic                   n_fault;
	logic                   n_wide;
	logic                   n_open;
	logic [1:0]             n_qkind;
	clt_pkg::esc_t          n_esc;
	logic [1:0]             n_elen;
	logic [COUNT_WIDTH-1:0] n_lcount;
	logic [1:0]             n_raw;
	logic [1:0]             add;
	logic [COUNT_WIDTH:0]   sum;
	logic [1:0]             status;
	logic [1:0]             kind;
	logic [7:0]             c;
	logic [7:0]             q;
	logic [OCW-1:0]         count_out;
	logic                   accept;
	clt_pkg::result_t       res;

	assign c      = req.ch;
	assign accept = req.valid && req.ready;

	// A start request clears the state before the byte is handled.
	always_comb begin
		cur_fault  = req.start_req ? 1'b0 : fault_q;
		cur_wide   = req.start_req ? 1'b0 : wide_q;
		cur_open   = req.start_req ? 1'b0 : open_q;
		cur_qkind  = req.start_req ? clt_pkg::KIND_NONE : qkind_q;
		cur_esc    = req.start_req ? clt_pkg::ESC_NONE : esc_q;
		cur_elen   = req.start_req ? 2'd0 : elen_q;
		cur_lcount = req.start_req ? '0 : lcount_q;
		cur_raw    = req.start_req ? 2'd0 : raw_q;
	end

	assign q = (cur_qkind == clt_pkg::KIND_STRING) ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE;

	// Per-byte recogniser step.
	always_comb begin
		n_fault  = cur_fault;
		n_wide   = cur_wide;
		n_open   = cur_open;
		n_qkind  = cur_qkind;
		n_esc    = cur_esc;
		n_elen   = cur_elen;
		n_raw    = cur_raw;
		add      = 2'd0;
		status   = clt_pkg::ST_ERROR;
		kind     = clt_pkg::KIND_NONE;
		if (!cur_fault) begin
			if (cur_raw == 2'd0) begin
				if (c == clt_pkg::CH_L) begin
					n_wide = 1'b1;
					status = clt_pkg::ST_PARTIAL;
				end else if (c == clt_pkg::CH_DQUOTE) begin
					n_open  = 1'b1;
					n_qkind = clt_pkg::KIND_STRING;
					status  = clt_pkg::ST_PARTIAL;
				end else if (c == clt_pkg::CH_SQUOTE) begin
					n_open  = 1'b1;
					n_qkind = clt_pkg::KIND_CHAR;
					status  = clt_pkg::ST_PARTIAL;
				end
			end else if (cur_raw == 2'd1 && cur_wide && !cur_open &&
					cur_qkind == clt_pkg::KIND_NONE) begin
				if (c == clt_pkg::CH_DQUOTE) begin
					n_open  = 1'b1;
					n_qkind = clt_pkg::KIND_STRING;
					status  = clt_pkg::ST_PARTIAL;
				end else if (c == clt_pkg::CH_SQUOTE) begin
					n_open  = 1'b1;
					n_qkind = clt_pkg::KIND_CHAR;
					status  = clt_pkg::ST_PARTIAL;
				end
			end else if (cur_open) begin
				unique case (cur_esc)
					clt_pkg::ESC_NONE: begin
						if (c == q) begin
							n_open = 1'b0;
							status = clt_pkg::ST_PARTIAL;
						end else if (c == clt_pkg::CH_BSLASH) begin
							n_esc  = clt_pkg::ESC_BACKSLASH;
							n_elen = 2'd1;
							status = clt_pkg::ST_PARTIAL;
						end else if (c != clt_pkg::CH_NL) begin
							add    = 2'd1;
							status = clt_pkg::ST_PARTIAL;
						end
					end
					clt_pkg::ESC_BACKSLASH: begin
						if (clt_pkg::is_simple_esc(c)) begin
							n_esc  = clt_pkg::ESC_NONE;
							n_elen = 2'd0;
							add    = 2'd1;
							status = clt_pkg::ST_PARTIAL;
						end else if (clt_pkg::is_oct(c)) begin
							n_esc  = clt_pkg::ESC_OCTAL;
							n_elen = 2'd2;
							status = clt_pkg::ST_PARTIAL;
						end else if (c == clt_pkg::CH_LC_X || c == clt_pkg::CH_UC_X) begin
							n_esc  = clt_pkg::ESC_HEX;
							n_elen = 2'd2;
							status = clt_pkg::ST_PARTIAL;
						end
					end
					default: begin
						// Digits extend it (octal to three); hex with no digit errors; else it ends.
						if (cur_esc == clt_pkg::ESC_OCTAL && clt_pkg::is_oct(c)) begin
							status = clt_pkg::ST_PARTIAL;
							if (cur_elen == 2'd3) begin
								n_esc  = clt_pkg::ESC_NONE;
								n_elen = 2'd0;
								add    = 2'd1;
							end else begin
								n_elen = cur_elen + 2'd1;
							end
						end else if (cur_esc == clt_pkg::ESC_HEX && clt_pkg::is_hex(c)) begin
							n_elen = 2'd3;
							status = clt_pkg::ST_PARTIAL;
						end else if (cur_esc == clt_pkg::ESC_HEX && cur_elen != 2'd3) begin
							status = clt_pkg::ST_ERROR;
						end else if (c == q) begin
							n_esc  = clt_pkg::ESC_NONE;
							n_elen = 2'd0;
							add    = 2'd1;
							n_open = 1'b0;
							status = clt_pkg::ST_PARTIAL;
						end else if (c == clt_pkg::CH_BSLASH) begin
							n_esc  = clt_pkg::ESC_BACKSLASH;
							n_elen = 2'd1;
							add    = 2'd1;
							status = clt_pkg::ST_PARTIAL;
						end else if (c != clt_pkg::CH_NL) begin
							n_esc  = clt_pkg::ESC_NONE;
							n_elen = 2'd0;
							add    = 2'd2;
							status = clt_pkg::ST_PARTIAL;
						end
					end
				endcase
			end
			n_raw = (cur_raw == 2'd2) ? 2'd2 : cur_raw + 2'd1;
			if (status == clt_pkg::ST_PARTIAL && n_qkind != clt_pkg::KIND_NONE && !n_open) begin
				status = clt_pkg::ST_COMPLETE;
				kind   = n_qkind;
			end
			n_fault = (status == clt_pkg::ST_ERROR);
		end
	end

	// Saturating logical character count.
	assign sum      = {1'b0, cur_lcount} + (COUNT_WIDTH+1)'(add);
	assign n_lcount = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

	// Fit the count to the result field, saturating if it is wider.
	generate
		if (COUNT_WIDTH > OCW) begin : g_count_sat
			assign count_out = (|n_lcount[COUNT_WIDTH-1:OCW]) ? '1 : n_lcount[OCW-1:0];
		end else begin : g_count_ext
			assign count_out = OCW'(n_lcount);
		end
	endgenerate

	assign res.status        = status;
	assign res.token_kind    = kind;
	assign res.is_wide       = n_wide;
	assign res.logical_chars = count_out;

	// Recogniser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q  <= 1'b0;
			wide_q   <= 1'b0;
			open_q   <= 1'b0;
			qkind_q  <= clt_pkg::KIND_NONE;
			esc_q    <= clt_pkg::ESC_NONE;
			elen_q   <= 2'd0;
			lcount_q <= '0;
			raw_q    <= 2'd0;
		end else if (accept) begin
			fault_q  <= n_fault;
			wide_q   <= n_wide;
			open_q   <= n_open;
			qkind_q  <= n_qkind;
			esc_q    <= n_esc;
			elen_q   <= n_elen;
			lcount_q <= n_lcount;
			raw_q    <= n_raw;
		end
	end

	// Result slot occupancy: the skid slot fills only when the result slot stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign req.ready         = !skid_valid_q;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.token_kind    = out_q.token_kind;
	assign rsp.is_wide       = out_q.is_wide;
	assign rsp.logical_chars = out_q.logical_chars;

endmodule

`default_nettype wire

@@ sv/clt_checker.sv @@
`default_nettype none

module clt_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire [1:0]                          status,
	input wire [1:0]                          token_kind,
	input wire                                is_wide,
	input wire [clt_pkg::OUT_COUNT_WIDTH-1:0] logical_chars
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(token_kind) && $stable(is_wide) && $stable(logical_chars))
		else $error("stalled result beat changed");

	// The status is always one of error, partial or complete.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == clt_pkg::ST_ERROR || status == clt_pkg::ST_PARTIAL ||
		status == clt_pkg::ST_COMPLETE))
		else $error("illegal status code");

	// A complete result names a string or a character constant; any other has no kind.
	a_kind_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == clt_pkg::ST_COMPLETE) ?
		(token_kind == clt_pkg::KIND_STRING || token_kind == clt_pkg::KIND_CHAR) :
		(token_kind == clt_pkg::KIND_NONE)))
		else $error("token kind does not match status");

	// With no result pending the skid slot is empty, so a byte can always enter.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// A byte taken while no result is pending shows its result after that edge.
	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("accepted byte produced no result");

endmodule

bind c_literal_token_recognizer_core clt_checker u_clt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.status        (rsp.status),
	.token_kind    (rsp.token_kind),
	.is_wide       (rsp.is_wide),
	.logical_chars (rsp.logical_chars)
);

`default_nettype wire
